// ----- sv/ipu_pkg.sv -----
// shared types and constants for the integer pixel upscaler
// used by ipu_emitter and integer_pixel_upscaler_unit; no dependencies
package ipu_pkg;

  // fixed field widths
  localparam int unsigned PIXEL_W     = 24;
  localparam int unsigned PAD_W       = 2;
  localparam int unsigned CFG_WIDTH_W = 11;
  localparam int unsigned CFG_SCALE_W = 7;
  localparam int unsigned CFG_DATA_W  = 11;
  localparam int unsigned CFG_IDX_W   = 1;
  // copy and row-pass counters cover scale values up to 64
  localparam int unsigned REPS_W      = 6;

  // input word opcodes
  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_REPLAY = 1'b1
  } opcode_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_WIDTH = 1'b0,
    REG_SCALE        = 1'b1
  } cfg_reg_e;

  // one word handed to the copy emitter
  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic [PAD_W-1:0]   pad;
    logic               row_end;
    logic               group_end;
    logic [REPS_W-1:0]  reps;    // number of copies minus one
  } item_t;

endpackage

// ----- sv/ipu_emitter.sv -----
// copy emitter: holds one pixel word and sends it out reps+1 times
// depends on ipu_pkg (item_t)
module ipu_emitter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              item_valid_i,
  output logic                              item_ready_o,
  input  ipu_pkg::item_t                    item_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [ipu_pkg::PIXEL_W-1:0]       out_pixel_o,
  output logic [ipu_pkg::PAD_W-1:0]         pad_bytes_o,
  output logic                              row_end_o,
  output logic                              group_end_o,
  output logic                              last_o
);
  import ipu_pkg::*;

  logic                busy_q, busy_d;
  item_t               item_q, item_d;
  logic [REPS_W-1:0]   cnt_q, cnt_d;
  logic                final_copy;

  // final copy of the held word
  assign final_copy   = (cnt_q == '0);
  assign item_ready_o = !busy_q || (out_ready_i && final_copy);

  // copy counter and holding register
  always_comb begin
    busy_d = busy_q;
    item_d = item_q;
    cnt_d  = cnt_q;
    if (item_valid_i && item_ready_o) begin
      busy_d = 1'b1;
      item_d = item_i;
      cnt_d  = item_i.reps;
    end else if (busy_q && out_ready_i) begin
      if (final_copy) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - REPS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    cnt_q  <= cnt_d;
  end

  // output word
  assign out_valid_o = busy_q;
  assign out_pixel_o = item_q.pixel;
  assign last_o      = final_copy;
  assign row_end_o   = final_copy && item_q.row_end;
  assign group_end_o = final_copy && item_q.group_end;
  assign pad_bytes_o = (final_copy && item_q.row_end) ? item_q.pad : '0;

endmodule

// ----- sv/integer_pixel_upscaler_unit.sv -----
// nearest-neighbour integer upscaler top level: row tracking, line store, staging
// depends on ipu_pkg and ipu_emitter
//
// Each accepted load or replay word produces scale output words, one per cycle
// while out_ready_i is high, so the sustained input rate is set by the single
// copy emitter on the output side (scale is 1 to 64).
// After the input word is accepted, the first copy passes through the staging
// register, which also takes the registered read of the line store, then the
// emitter once it is free. A staging register sits between the two sides,
// so a new word is taken while the emitter is still sending copies. A load or
// replay word that arrives out of place is consumed and produces nothing.
// The line store holds MAX_WIDTH pixels and is read or written once per word;
// it needs no clearing after reset. Registers may only be written while idle.
module integer_pixel_upscaler_unit #(
  parameter int unsigned MAX_WIDTH = 1024,
  parameter int unsigned MAX_SCALE = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [ipu_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [ipu_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  // input words
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                opcode_i,
  input  logic [ipu_pkg::PIXEL_W-1:0]         pixel_i,
  // output words
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [ipu_pkg::PIXEL_W-1:0]         out_pixel_o,
  output logic [ipu_pkg::PAD_W-1:0]           pad_bytes_o,
  output logic                                row_end_o,
  output logic                                group_end_o,
  output logic                                last_o
);
  import ipu_pkg::*;

  localparam int unsigned COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned EW_W  = $clog2(MAX_WIDTH + 1);
  localparam logic [EW_W-1:0]        MAX_W_V = EW_W'(MAX_WIDTH);
  localparam logic [CFG_SCALE_W-1:0] MAX_S_V = CFG_SCALE_W'(MAX_SCALE);

  // configuration registers
  logic [CFG_WIDTH_W-1:0] source_width_q;
  logic [CFG_SCALE_W-1:0] scale_q;

  // row tracking state
  logic [COL_W-1:0]  column_q, column_d;
  logic [REPS_W-1:0] row_pass_q, row_pass_d;
  logic              replaying_q, replaying_d;

  // staging register
  logic              a_valid_q, a_valid_d;
  logic              a_replay_q;
  item_t             a_item_q;
  logic [PIXEL_W-1:0] rd_q;

  // line store
  logic [PIXEL_W-1:0] line_mem [MAX_WIDTH];

  logic              in_acc, in_place, take;
  logic [EW_W-1:0]   eff_w;
  logic [CFG_SCALE_W-1:0] eff_s;
  logic              at_row_end, at_group_end;
  logic [PAD_W-1:0]  pad;
  logic              item_ready;
  item_t             b_item;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      source_width_q <= CFG_WIDTH_W'(1);
      scale_q        <= CFG_SCALE_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_SOURCE_WIDTH: source_width_q <= cfg_wdata_i;
        REG_SCALE:        scale_q        <= cfg_wdata_i[CFG_SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped width and scale
  always_comb begin
    if (source_width_q == '0) begin
      eff_w = EW_W'(1);
    end else if (32'(source_width_q) > 32'(MAX_WIDTH)) begin
      eff_w = MAX_W_V;
    end else begin
      eff_w = EW_W'(source_width_q);
    end
    if (scale_q == '0) begin
      eff_s = CFG_SCALE_W'(1);
    end else if (scale_q > MAX_S_V) begin
      eff_s = MAX_S_V;
    end else begin
      eff_s = scale_q;
    end
  end

  // row and group position of the incoming word
  assign at_row_end   = ((EW_W+1)'(column_q) + (EW_W+1)'(1)) >= (EW_W+1)'(eff_w);
  assign at_group_end = at_row_end &&
                        ((CFG_SCALE_W'(row_pass_q) + CFG_SCALE_W'(1)) >= eff_s);
  assign pad          = PAD_W'(PAD_W'(eff_w) * PAD_W'(eff_s));

  // input handshake
  assign in_ready_o = !a_valid_q || item_ready;
  assign in_acc     = in_valid_i && in_ready_o;
  assign in_place   = (opcode_i == OP_REPLAY) == replaying_q;
  assign take       = in_acc && in_place;

  // state update per word
  always_comb begin
    column_d    = column_q;
    row_pass_d  = row_pass_q;
    replaying_d = replaying_q;
    if (take) begin
      if (!at_row_end) begin
        column_d = column_q + COL_W'(1);
      end else begin
        column_d = '0;
        if (at_group_end) begin
          row_pass_d  = '0;
          replaying_d = 1'b0;
        end else begin
          row_pass_d  = row_pass_q + REPS_W'(1);
          replaying_d = 1'b1;
        end
      end
    end
  end

  // staging register occupancy
  always_comb begin
    a_valid_d = a_valid_q;
    if (take) begin
      a_valid_d = 1'b1;
    end else if (item_ready) begin
      a_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q    <= '0;
      row_pass_q  <= '0;
      replaying_q <= 1'b0;
      a_valid_q   <= 1'b0;
    end else begin
      column_q    <= column_d;
      row_pass_q  <= row_pass_d;
      replaying_q <= replaying_d;
      a_valid_q   <= a_valid_d;
    end
  end

  // staging payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      a_replay_q         <= (opcode_i == OP_REPLAY);
      a_item_q.pixel     <= pixel_i;
      a_item_q.pad       <= pad;
      a_item_q.row_end   <= at_row_end;
      a_item_q.group_end <= at_group_end;
      a_item_q.reps      <= REPS_W'(eff_s - CFG_SCALE_W'(1));
    end
  end

  // line store: write on load, registered read on replay
  always_ff @(posedge clk_i) begin
    if (take && (opcode_i == OP_LOAD)) begin
      line_mem[column_q] <= pixel_i;
    end
    if (take && (opcode_i == OP_REPLAY)) begin
      rd_q <= line_mem[column_q];
    end
  end

  // word to the emitter takes the stored pixel on replay
  always_comb begin
    b_item       = a_item_q;
    b_item.pixel = a_replay_q ? rd_q : a_item_q.pixel;
  end

  ipu_emitter u_emitter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (a_valid_q),
    .item_ready_o (item_ready),
    .item_i       (b_item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_pixel_o  (out_pixel_o),
    .pad_bytes_o  (pad_bytes_o),
    .row_end_o    (row_end_o),
    .group_end_o  (group_end_o),
    .last_o       (last_o)
  );

  // checks
  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q && !item_ready |=> a_valid_q)
    else $error("staged word lost while emitter busy");

  a_pass_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !replaying_q |-> row_pass_q == '0)
    else $error("row pass count nonzero while expecting loads");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(column_q) < MAX_WIDTH)
    else $error("column beyond line store");

  a_group_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && group_end_o |-> row_end_o && last_o)
    else $error("group end without row end and last");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !a_valid_q |-> in_ready_o)
    else $error("input stalled with empty staging register");

endmodule

// ----- bench/integer_pixel_upscaler_unit_tb.sv -----
`timescale 1ns / 100ps
// testbench for integer_pixel_upscaler_unit: directed and random load/replay words under
// changing stall patterns, every output word checked against an in-bench row predictor
// depends on ipu_pkg and integer_pixel_upscaler_unit
module integer_pixel_upscaler_unit_tb;
  import ipu_pkg::*;

  localparam int unsigned MaxWidth      = 1024;
  localparam int unsigned MaxScale      = 64;
  localparam int unsigned SettleCycles  = 12;
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned ReportLimit   = 10;
  // three bytes per pixel and rows padded to four bytes: pad equals pixel count mod 4
  localparam int unsigned RowAlign      = 4;

  // one input word and one output word
  typedef struct packed {
    opcode_e            op;
    logic [PIXEL_W-1:0] pixel;
  } src_word_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic [PAD_W-1:0]   pad;
    logic               row_end;
    logic               group_end;
    logic               last;
  } copy_word_t;

  // the row tracker exists twice: one copy plans stimulus, one follows accepted words
  typedef enum bit {
    PLAN_TRACK  = 1'b0,
    CHECK_TRACK = 1'b1
  } track_e;

  logic                   clk;
  logic                   rst_n     = 1'b0;
  logic                   cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  logic                   opcode    = 1'b0;
  logic [PIXEL_W-1:0]     pixel     = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [PIXEL_W-1:0]     out_pixel;
  logic [PAD_W-1:0]       pad_bytes;
  logic                   row_end;
  logic                   group_end;
  logic                   last;

  // predictor state
  logic [CFG_WIDTH_W-1:0] width_reg = 1;
  logic [CFG_SCALE_W-1:0] scale_reg = 1;
  bit   [9:0]             column_q   [2];
  bit   [REPS_W-1:0]      row_pass_q [2];
  bit                     replaying_q [2];
  logic [PIXEL_W-1:0]     line_store [MaxWidth];

  src_word_t              pending_words[$];
  copy_word_t             expected_copies[$];
  src_word_t              next_word;
  src_word_t              seen_word;
  copy_word_t             got;
  copy_word_t             want;

  logic                   in_fire = 1'b0;
  int unsigned            send_idle_pct = 0;
  int unsigned            recv_stall_pct = 0;
  int unsigned            hold_req = 0;
  int unsigned            hold_seen = 0;
  int unsigned            hold_left = 0;
  int unsigned            err_cnt = 0;
  int unsigned            quiet_cycles = 0;

  integer_pixel_upscaler_unit i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .opcode_i    (opcode),
    .pixel_i     (pixel),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_pixel_o (out_pixel),
    .pad_bytes_o (pad_bytes),
    .row_end_o   (row_end),
    .group_end_o (group_end),
    .last_o      (last)
  );

  // clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // register values as the block sees them
  function automatic int unsigned eff_width(int unsigned raw);
    if (raw == 0) return 1;
    if (raw > MaxWidth) return MaxWidth;
    return raw;
  endfunction

  function automatic int unsigned eff_scale(int unsigned raw);
    if (raw == 0) return 1;
    if (raw > MaxScale) return MaxScale;
    return raw;
  endfunction

  // advance one tracker by one word; the checking copy also queues the pixel copies
  function automatic void upscale_word(track_e trk, src_word_t w);
    int unsigned        wid;
    int unsigned        scl;
    int unsigned        col;
    int unsigned        rp;
    int unsigned        k;
    bit                 at_row_end;
    bit                 at_group_end;
    logic [PIXEL_W-1:0] value;
    copy_word_t         c;
    wid = eff_width(width_reg);
    scl = eff_scale(scale_reg);
    col = column_q[trk];
    rp  = row_pass_q[trk];
    // out-of-place words are swallowed and change nothing
    if ((w.op == OP_REPLAY) != replaying_q[trk]) return;
    if (w.op == OP_LOAD) begin
      value = w.pixel;
      if (trk == CHECK_TRACK) line_store[col] = w.pixel;
    end else begin
      value = line_store[col];
    end
    at_row_end   = (col + 1 >= wid);
    at_group_end = at_row_end && (rp + 1 >= scl);
    if (trk == CHECK_TRACK) begin
      for (k = 0; k < scl; k++) begin
        c.pixel     = value;
        c.last      = (k + 1 == scl);
        c.row_end   = c.last && at_row_end;
        c.group_end = c.last && at_group_end;
        c.pad       = c.row_end ? PAD_W'((wid * scl) % RowAlign) : '0;
        expected_copies.push_back(c);
      end
    end
    // row and group bookkeeping
    if (!at_row_end) begin
      column_q[trk] = column_q[trk] + 1'b1;
    end else begin
      column_q[trk] = '0;
      if (at_group_end) begin
        row_pass_q[trk]  = '0;
        replaying_q[trk] = 1'b0;
      end else begin
        row_pass_q[trk]  = row_pass_q[trk] + 1'b1;
        replaying_q[trk] = 1'b1;
      end
    end
  endfunction

  // queue one word for the driver and advance the planning tracker
  task automatic plan_word(opcode_e op, logic [PIXEL_W-1:0] pix);
    src_word_t w;
    w.op    = op;
    w.pixel = pix;
    upscale_word(PLAN_TRACK, w);
    pending_words.push_back(w);
  endtask

  // well-formed load/replay sequences with random pixels, sprinkled with stray words
  task automatic plan_stream(int unsigned n);
    int unsigned placed;
    opcode_e     op;
    placed = 0;
    while (placed < n) begin
      op = replaying_q[PLAN_TRACK] ? OP_REPLAY : OP_LOAD;
      if ($urandom_range(99) < 8) begin
        plan_word((op == OP_LOAD) ? OP_REPLAY : OP_LOAD, PIXEL_W'($urandom));
      end else begin
        plan_word(op, PIXEL_W'($urandom));
        placed++;
      end
    end
  endtask

  // block drained: nothing queued, offered or outstanding, then its latency
  task automatic wait_idle();
    while (pending_words.size() != 0 || in_valid || expected_copies.size() != 0)
      @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_SOURCE_WIDTH) width_reg = CFG_WIDTH_W'(val);
    else scale_reg = CFG_SCALE_W'(val);
  endtask

  task automatic set_config(int unsigned w_raw, int unsigned s_raw);
    wait_idle();
    // replays only reach entries loaded earlier, so a running replay never widens
    if (replaying_q[PLAN_TRACK] && eff_width(w_raw) > eff_width(width_reg))
      w_raw = eff_width(width_reg);
    write_reg(REG_SOURCE_WIDTH, CFG_DATA_W'(w_raw));
    write_reg(REG_SCALE, CFG_DATA_W'(s_raw));
  endtask

  task automatic set_idling(int unsigned mode);
    case (mode)
      0: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct  = 56;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct  = 0;
        recv_stall_pct = 56;
      end
      default: begin
        send_idle_pct  = 33;
        recv_stall_pct = 33;
      end
    endcase
  endtask

  // input driver: next word offered only once the current one is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_word = pending_words.pop_front();
        in_valid <= 1'b1;
        opcode   <= next_word.op;
        pixel    <= next_word.pixel;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output receiver: random stalls plus an occasional long hold-off
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: predict on each accepted input word, check each accepted output word
  always @(posedge clk) begin
    in_fire <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      seen_word.op    = opcode_e'(opcode);
      seen_word.pixel = pixel;
      upscale_word(CHECK_TRACK, seen_word);
    end
    if (rst_n && out_valid && out_ready) begin
      got.pixel     = out_pixel;
      got.pad       = pad_bytes;
      got.row_end   = row_end;
      got.group_end = group_end;
      got.last      = last;
      if (expected_copies.size() == 0) begin
        err_cnt++;
        if (err_cnt <= ReportLimit)
          $display("%0t: output word %h arrived with nothing expected", $time, got);
      end else begin
        want = expected_copies.pop_front();
        if (got.pixel !== want.pixel || got.pad !== want.pad ||
            got.row_end !== want.row_end || got.group_end !== want.group_end ||
            got.last !== want.last) begin
          err_cnt++;
          if (err_cnt <= ReportLimit)
            $display("%0t: mismatch exp/act pixel %h/%h pad %0d/%0d row_end %b/%b",
                     $time, want.pixel, got.pixel, want.pad, got.pad,
                     want.row_end, got.row_end,
                     "  group_end %b/%b last %b/%b",
                     want.group_end, got.group_end, want.last, got.last);
        end
      end
    end
  end

  // watchdog on cycles without any word accepted
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    int unsigned ph;
    int unsigned w_raw;
    int unsigned s_raw;
    int unsigned n;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    set_idling(0);

    // short rows: stray words on both sides, extreme pixels, padded row end
    set_config(3, 2);
    plan_word(OP_REPLAY, 24'h123456);
    plan_word(OP_LOAD,   24'h000000);
    plan_word(OP_LOAD,   24'hFFFFFF);
    plan_word(OP_LOAD,   24'h5A5A5A);
    plan_word(OP_LOAD,   24'hFFFFFF);
    plan_word(OP_REPLAY, 24'h000000);
    plan_word(OP_REPLAY, 24'hFFFFFF);
    plan_word(OP_REPLAY, 24'hA5A5A5);

    // oversized width saturates, zero scale acts as one, then width cut to zero mid-row
    set_config(11'h7FF, 0);
    plan_word(OP_LOAD, 24'hA5A5A5);
    plan_word(OP_LOAD, 24'h5A5A5A);
    plan_word(OP_LOAD, 24'hFFFFFF);
    plan_word(OP_LOAD, 24'h0F0F0F);
    set_config(0, 0);
    plan_word(OP_LOAD, 24'hF0F0F0);

    // oversized scale on a one-pixel row, then the group ended early by scale one
    set_config(1, 127);
    plan_word(OP_LOAD, 24'hC3C3C3);
    set_config(1, 1);
    plan_word(OP_REPLAY, 24'h000000);

    // random phases across settings and stall patterns
    for (ph = 0; ph < 8; ph++) begin
      if (ph == 3) begin
        w_raw = 1;
        s_raw = MaxScale;
        n     = 70;
      end else if (ph == 6) begin
        w_raw = $urandom_range(40, 20);
        s_raw = $urandom_range(3, 1);
        n     = 30;
      end else begin
        w_raw = $urandom_range(6, 1);
        s_raw = $urandom_range(12, 1);
        n     = 28;
      end
      set_config(w_raw, s_raw);
      set_idling(ph % 4);
      plan_stream(n);
      // receiver holds off while the sender keeps pushing, filling the block
      if (ph == 4) hold_req = hold_req + 1;
    end

    wait_idle();
    if (err_cnt == 0 && expected_copies.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
